// ===== rtl/dcsg_pkg.sv =====
// ----------------------------------------------------------------------------
// Drive command safety governor package
// Shared types, command and result codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package dcsg_pkg;

  localparam logic [2:0] CMD_MANUAL = 3'd0;
  localparam logic [2:0] CMD_AUTO   = 3'd1;
  localparam logic [2:0] CMD_STOP   = 3'd2;
  localparam logic [2:0] CMD_MODE   = 3'd3;
  localparam logic [2:0] CMD_RAY    = 3'd4;
  localparam logic [2:0] CMD_TICK   = 3'd5;

  localparam logic [1:0] KIND_EFFORT = 2'd0;
  localparam logic [1:0] KIND_FRONT  = 2'd1;
  localparam logic [1:0] KIND_REAR   = 2'd2;

  localparam logic [2:0] REG_MANUAL_GAIN   = 3'd0;
  localparam logic [2:0] REG_AUTO_GAIN     = 3'd1;
  localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd2;
  localparam logic [2:0] REG_SAFETY_MM     = 3'd3;
  localparam logic [2:0] REG_SONAR_MIN_MM  = 3'd4;
  localparam logic [2:0] REG_SONAR_MAX_MM  = 3'd5;

  localparam logic [15:0] RANGE_RESET = 16'd4000;
  localparam logic [7:0]  AGE_MAX     = 8'hFF;

  typedef struct packed {
    logic [15:0] manual_gain;
    logic [15:0] auto_gain;
    logic [7:0]  timeout_ticks;
    logic [15:0] safety_mm;
    logic [15:0] sonar_min_mm;
    logic [15:0] sonar_max_mm;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    manual_gain:   16'd4096,
    auto_gain:     16'd6144,
    timeout_ticks: 8'd20,
    safety_mm:     16'd300,
    sonar_min_mm:  16'd0,
    sonar_max_mm:  16'd4000
  };

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [15:0] linear_vel;
    logic signed [15:0] angular_vel;
    logic               button_level;
    logic               sonar_side;
    logic [15:0]        ray_mm;
    logic               ray_finite;
    logic               ray_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        range;
    logic signed [15:0] lin;
    logic signed [15:0] ang;
    logic [15:0]        gain;
    logic               front_near;
    logic               rear_near;
  } sel_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        range;
    logic signed [32:0] pl;
    logic signed [32:0] pa;
    logic               front_near;
    logic               rear_near;
  } prod_t;

endpackage

`default_nettype wire

// ===== rtl/dcsg_if.sv =====
// ----------------------------------------------------------------------------
// Drive command safety governor channels
// Event input channel, result output channel and register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcsg_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic signed [15:0] linear_vel;
  logic signed [15:0] angular_vel;
  logic               button_level;
  logic               sonar_side;
  logic [15:0]        ray_mm;
  logic               ray_finite;
  logic               ray_last;

  modport source (
    output valid, cmd, linear_vel, angular_vel, button_level, sonar_side,
           ray_mm, ray_finite, ray_last,
    input  ready
  );
  modport sink (
    input  valid, cmd, linear_vel, angular_vel, button_level, sonar_side,
           ray_mm, ray_finite, ray_last,
    output ready
  );
endinterface

interface dcsg_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic signed [16:0] right_effort;
  logic signed [16:0] left_effort;
  logic [15:0]        range_mm;
  logic               forward_blocked;
  logic               reverse_blocked;

  modport source (
    output valid, result_kind, right_effort, left_effort, range_mm,
           forward_blocked, reverse_blocked,
    input  ready
  );
  modport sink (
    input  valid, result_kind, right_effort, left_effort, range_mm,
           forward_blocked, reverse_blocked,
    output ready
  );
endinterface

interface dcsg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/drive_command_safety_governor_top.sv =====
// ----------------------------------------------------------------------------
// Drive command safety governor
// Command arbitration with timeouts, sonar range latching and obstacle
// blocking; emits differential wheel efforts per control tick and sonar ranges.
//
//   Channel  Direction  Payload
//   item     in         cmd, velocities, button level, sonar ray fields
//   result   out        result kind, wheel efforts, range, blocked flags
//   cfg      in         register index and write data
//
// An item is accepted every cycle while the stages are not all full; a result
// passes through the input register, state and selection stage, multiply stage
// and result register; the multiply stage holds the 17 by 17 bit multipliers.
// rst clears all stages and loads the register and state reset values.
// A stalled result holds the stages behind it; item.ready falls only once the
// input register and every stage after it are full.
// ----------------------------------------------------------------------------
`default_nettype none

module drive_command_safety_governor_top
  import dcsg_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  dcsg_in_if.sink     item,
  dcsg_out_if.source  result,
  dcsg_cfg_if.sink    cfg
);

  cfg_t  regs;
  logic  sel_valid;
  sel_t  sel;
  logic  load_prod;
  logic  prod_valid;
  prod_t prod;
  logic  load_res;

  dcsg_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  dcsg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .regs      (regs),
    .load_next (load_prod),
    .sel_valid (sel_valid),
    .sel       (sel)
  );

  dcsg_mult u_mult (
    .clk        (clk),
    .rst        (rst),
    .sel_valid  (sel_valid),
    .sel        (sel),
    .load_next  (load_res),
    .load_prod  (load_prod),
    .prod_valid (prod_valid),
    .prod       (prod)
  );

  dcsg_finish u_finish (
    .clk        (clk),
    .rst        (rst),
    .prod_valid (prod_valid),
    .prod       (prod),
    .load_res   (load_res),
    .result     (result)
  );

  a_sel_held: assert property (@(posedge clk) disable iff (rst)
    sel_valid && !load_prod |=> sel_valid)
    else $error("Selection stage lost an item while stalled.");

  a_fwd_block: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.forward_blocked |->
      result.result_kind == KIND_EFFORT &&
      (result.right_effort + result.left_effort) == 17'sd0)
    else $error("Forward block left linear motion in the efforts.");

  a_range_clean: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.result_kind != KIND_EFFORT |->
      result.right_effort == 17'sd0 && result.left_effort == 17'sd0 &&
      !result.forward_blocked && !result.reverse_blocked)
    else $error("Range result carries effort fields.");

  a_prod_from_sel: assert property (@(posedge clk) disable iff (rst)
    load_prod && !sel_valid |=> !prod_valid)
    else $error("Multiply stage became valid without an item.");

endmodule

`default_nettype wire

// ===== rtl/dcsg_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the gains, timeout, safety distance and sonar bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module dcsg_cfg_regs
  import dcsg_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  dcsg_cfg_if.sink    cfg,
  output cfg_t        regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= CFG_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_MANUAL_GAIN:   regs.manual_gain   <= cfg.data;
        REG_AUTO_GAIN:     regs.auto_gain     <= cfg.data;
        REG_TIMEOUT_TICKS: regs.timeout_ticks <= cfg.data[7:0];
        REG_SAFETY_MM:     regs.safety_mm     <= cfg.data;
        REG_SONAR_MIN_MM:  regs.sonar_min_mm  <= cfg.data;
        REG_SONAR_MAX_MM:  regs.sonar_max_mm  <= cfg.data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dcsg_front.sv =====
// ----------------------------------------------------------------------------
// Event stage
// Input register, governor state, sonar minimum tracking and source selection.
// ----------------------------------------------------------------------------
`default_nettype none

module dcsg_front
  import dcsg_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  dcsg_in_if.sink     item,
  input  wire cfg_t   regs,
  input  wire logic   load_next,
  output logic        sel_valid,
  output sel_t        sel
);

  logic        in_valid;
  in_item_t    in_item;
  logic        load_in;
  logic        load_sel;

  logic signed [15:0] manual_linear, manual_linear_next;
  logic signed [15:0] manual_angular, manual_angular_next;
  logic signed [15:0] auto_linear, auto_linear_next;
  logic signed [15:0] auto_angular, auto_angular_next;
  logic [7:0]         manual_age, manual_age_next;
  logic [7:0]         auto_age, auto_age_next;
  logic               stop_active, stop_active_next;
  logic               auto_selected, auto_selected_next;
  logic [15:0]        front_range, front_range_next;
  logic [15:0]        rear_range, rear_range_next;
  logic [15:0]        scan_minimum [2];
  logic [15:0]        scan_minimum_next [2];

  logic        has_result;
  sel_t        sel_next;
  logic [15:0] cur_min;
  logic [15:0] new_min;
  logic [15:0] latched;
  logic        ray_ok;
  logic        drive;

  assign load_sel   = !sel_valid || load_next;
  assign load_in    = !in_valid || load_sel;
  assign item.ready = load_in;

  always_comb begin
    manual_linear_next   = manual_linear;
    manual_angular_next  = manual_angular;
    auto_linear_next     = auto_linear;
    auto_angular_next    = auto_angular;
    manual_age_next      = manual_age;
    auto_age_next        = auto_age;
    stop_active_next     = stop_active;
    auto_selected_next   = auto_selected;
    front_range_next     = front_range;
    rear_range_next      = rear_range;
    scan_minimum_next[0] = scan_minimum[0];
    scan_minimum_next[1] = scan_minimum[1];
    has_result           = 1'b0;
    sel_next             = '0;
    drive                = 1'b0;

    cur_min = scan_minimum[in_item.sonar_side];
    ray_ok  = in_item.ray_finite && (in_item.ray_mm >= regs.sonar_min_mm) &&
              (in_item.ray_mm <= regs.sonar_max_mm) && (in_item.ray_mm < cur_min);
    new_min = ray_ok ? in_item.ray_mm : cur_min;
    latched = (new_min < regs.sonar_max_mm) ? new_min : regs.sonar_max_mm;

    unique case (in_item.cmd)
      CMD_MANUAL: begin
        manual_linear_next  = in_item.linear_vel;
        manual_angular_next = in_item.angular_vel;
        manual_age_next     = '0;
      end
      CMD_AUTO: begin
        auto_linear_next  = in_item.linear_vel;
        auto_angular_next = in_item.angular_vel;
        auto_age_next     = '0;
      end
      CMD_STOP: begin
        stop_active_next = in_item.button_level;
        if (in_item.button_level) begin
          manual_linear_next  = '0;
          manual_angular_next = '0;
          auto_linear_next    = '0;
          auto_angular_next   = '0;
        end
      end
      CMD_MODE: begin
        auto_selected_next = in_item.button_level;
        if (!in_item.button_level) begin
          auto_linear_next  = '0;
          auto_angular_next = '0;
        end
      end
      CMD_RAY: begin
        if (in_item.ray_last) begin
          scan_minimum_next[in_item.sonar_side] = regs.sonar_max_mm;
          if (in_item.sonar_side) begin
            rear_range_next = latched;
            sel_next.kind   = KIND_REAR;
          end else begin
            front_range_next = latched;
            sel_next.kind    = KIND_FRONT;
          end
          sel_next.range = latched;
          has_result     = 1'b1;
        end else begin
          scan_minimum_next[in_item.sonar_side] = new_min;
        end
      end
      CMD_TICK: begin
        if (auto_selected) begin
          drive = !stop_active && (auto_age < regs.timeout_ticks);
        end else begin
          drive = !stop_active && (manual_age < regs.timeout_ticks);
        end
        if (drive) begin
          sel_next.lin  = auto_selected ? auto_linear : manual_linear;
          sel_next.ang  = auto_selected ? auto_angular : manual_angular;
          sel_next.gain = auto_selected ? regs.auto_gain : regs.manual_gain;
        end
        sel_next.kind       = KIND_EFFORT;
        sel_next.front_near = front_range <= regs.safety_mm;
        sel_next.rear_near  = rear_range <= regs.safety_mm;
        manual_age_next = (manual_age == AGE_MAX) ? manual_age : manual_age + 8'd1;
        auto_age_next   = (auto_age == AGE_MAX) ? auto_age : auto_age + 8'd1;
        has_result      = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      sel_valid       <= 1'b0;
      manual_linear   <= '0;
      manual_angular  <= '0;
      auto_linear     <= '0;
      auto_angular    <= '0;
      manual_age      <= '0;
      auto_age        <= '0;
      stop_active     <= 1'b1;
      auto_selected   <= 1'b1;
      front_range     <= RANGE_RESET;
      rear_range      <= RANGE_RESET;
      scan_minimum[0] <= RANGE_RESET;
      scan_minimum[1] <= RANGE_RESET;
    end else begin
      if (load_in) begin
        in_valid <= item.valid;
      end
      if (load_sel) begin
        sel_valid <= in_valid && has_result;
        if (in_valid) begin
          manual_linear   <= manual_linear_next;
          manual_angular  <= manual_angular_next;
          auto_linear     <= auto_linear_next;
          auto_angular    <= auto_angular_next;
          manual_age      <= manual_age_next;
          auto_age        <= auto_age_next;
          stop_active     <= stop_active_next;
          auto_selected   <= auto_selected_next;
          front_range     <= front_range_next;
          rear_range      <= rear_range_next;
          scan_minimum[0] <= scan_minimum_next[0];
          scan_minimum[1] <= scan_minimum_next[1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      in_item.cmd          <= item.cmd;
      in_item.linear_vel   <= item.linear_vel;
      in_item.angular_vel  <= item.angular_vel;
      in_item.button_level <= item.button_level;
      in_item.sonar_side   <= item.sonar_side;
      in_item.ray_mm       <= item.ray_mm;
      in_item.ray_finite   <= item.ray_finite;
      in_item.ray_last     <= item.ray_last;
    end
    if (load_sel) begin
      sel <= sel_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dcsg_mult.sv =====
// ----------------------------------------------------------------------------
// Scaling multiply stage
// Multiplies the selected linear and angular commands by the source gain.
// ----------------------------------------------------------------------------
`default_nettype none

module dcsg_mult
  import dcsg_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   sel_valid,
  input  wire sel_t   sel,
  input  wire logic   load_next,
  output logic        load_prod,
  output logic        prod_valid,
  output prod_t       prod
);

  logic signed [16:0] lin_x;
  logic signed [16:0] ang_x;
  logic signed [16:0] gain_x;
  logic signed [33:0] pl_full;
  logic signed [33:0] pa_full;

  assign load_prod = !prod_valid || load_next;
  assign lin_x     = {sel.lin[15], sel.lin};
  assign ang_x     = {sel.ang[15], sel.ang};
  assign gain_x    = {1'b0, sel.gain};
  assign pl_full   = lin_x * gain_x;
  assign pa_full   = ang_x * gain_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (load_prod) begin
      prod_valid <= sel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_prod) begin
      prod.kind       <= sel.kind;
      prod.range      <= sel.range;
      prod.pl         <= pl_full[32:0];
      prod.pa         <= pa_full[32:0];
      prod.front_near <= sel.front_near;
      prod.rear_near  <= sel.rear_near;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dcsg_finish.sv =====
// ----------------------------------------------------------------------------
// Result stage
// Clamps, blocks toward near obstacles, rescales and forms wheel efforts, or passes ranges.
// ----------------------------------------------------------------------------
`default_nettype none

module dcsg_finish
  import dcsg_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   prod_valid,
  input  wire prod_t  prod,
  output logic        load_res,
  dcsg_out_if.source  result
);

  localparam logic signed [32:0] QLIM = 33'sd16777216;

  logic signed [25:0] pl_c;
  logic signed [25:0] pa_c;
  logic signed [25:0] pl_b;
  logic signed [25:0] pl_bias;
  logic signed [25:0] pa_bias;
  logic signed [13:0] v;
  logic signed [13:0] w;
  logic signed [14:0] sum;
  logic signed [14:0] diff;
  logic               fwd;
  logic               rev;
  logic               is_effort;

  function automatic logic signed [25:0] clamp26(input logic signed [32:0] p);
    logic signed [32:0] c;
    begin
      c = p;
      if (p > QLIM) begin
        c = QLIM;
      end else if (p < -QLIM) begin
        c = -QLIM;
      end
      return c[25:0];
    end
  endfunction

  assign load_res = !result.valid || result.ready;

  always_comb begin
    is_effort = prod.kind == KIND_EFFORT;
    pl_c      = clamp26(prod.pl);
    pa_c      = clamp26(prod.pa);
    fwd       = (prod.pl > 33'sd0) && prod.front_near;
    rev       = !fwd && (prod.pl < 33'sd0) && prod.rear_near;
    pl_b      = (fwd || rev) ? 26'sd0 : pl_c;
    pl_bias   = pl_b + (pl_b[25] ? 26'sd4095 : 26'sd0);
    pa_bias   = pa_c + (pa_c[25] ? 26'sd4095 : 26'sd0);
    v         = pl_bias[25:12];
    w         = pa_bias[25:12];
    sum       = {v[13], v} + {w[13], w};
    diff      = {v[13], v} - {w[13], w};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_res) begin
      result.valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      result.result_kind     <= prod.kind;
      result.right_effort    <= is_effort ? {sum, 2'b00} : 17'sd0;
      result.left_effort     <= is_effort ? {diff, 2'b00} : 17'sd0;
      result.range_mm        <= is_effort ? 16'd0 : prod.range;
      result.forward_blocked <= is_effort && fwd;
      result.reverse_blocked <= is_effort && rev;
    end
  end

endmodule

`default_nettype wire
